// ===== rtl/rmts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_pkg: shared types and constants of the rate-monotonic tick scheduler
// Holds the default sizes, the register index codes and the per-cell status.
// ----------------------------------------------------------------------------
package rmts_pkg;

   // Default sizing
   localparam int TaskSlotsDef = 8;
   localparam int TimeBitsDef  = 8;

   // Fixed field layout of the packed registers and the result masks
   localparam int MaxSlots   = 8;
   localparam int PackBits   = 8;
   localparam int TaskBits   = 4;
   localparam int TickBits   = 16;
   localparam int CsrIdxBits = 2;
   localparam int CsrDataBits = 64;
   localparam int ReqDataBits = 8;
   localparam int RspDataBits = 40;

   // Register index codes
   typedef enum logic [CsrIdxBits-1:0] {
      CSR_TASK_COUNT = 2'd0,
      CSR_EXEC_TIMES = 2'd1,
      CSR_PERIODS    = 2'd2
   } csr_index_type;

   // Status of one task cell for the current tick
   typedef struct packed {
      logic released;
      logic missed;
      logic runs;
   } cell_stat_type;

endpackage

// ===== rtl/rate_monotonic_tick_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler: rate-monotonic scheduler, one tick per item
// A chain of task cells, slot 0 first, releases jobs and passes the run
// grant down the chain; the result goes out through a two-entry buffer.
//
//   channel  direction  payload (low bit up)                        handshake
//   req      in         restart                                     tvalid/tready
//   rsp      out        running_task, released_mask, miss_mask,     tvalid/tready
//                       tick_index
//   csr      in         index, data (task_count/exec_times/periods) valid/ready
//
// One tick is taken per cycle; its result is registered, in the skid entry if
// the output is held. The run grant ripples combinationally down the cell
// chain. Reset clears task state, tick counter and registers. req_tready drops
// only while both output buffer entries are full; csr writes are always taken.
// ----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler
   import rmts_pkg::*;
#(
   parameter int TASK_SLOTS = TaskSlotsDef,
   parameter int TIME_BITS  = TimeBitsDef
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input items: restart
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ReqDataBits-1:0] req_tdata,   // [0] restart, [7:1] zero
   // Result items
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataBits-1:0] rsp_tdata,   // [3:0] running_task,
                                               // [11:4] released_mask,
                                               // [19:12] miss_mask,
                                               // [35:20] tick_index, [39:36] 0
   // Configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [CsrDataBits-1:0] csr_data
);

   logic [TaskBits-1:0]    task_count_ff;
   logic [CsrDataBits-1:0] exec_times_ff, periods_ff;
   logic [TickBits-1:0]    tick_ff, tick_cur;

   logic                   fire, restart;
   logic [TASK_SLOTS:0]    taken;
   cell_stat_type          stat [TASK_SLOTS];
   logic [TASK_SLOTS-1:0]  run_vec, rel_vec, miss_vec;
   logic [MaxSlots-1:0]    rel_mask, miss_mask;
   logic [TaskBits-1:0]    run_task;
   logic [RspDataBits-1:0] rsp_new;

   logic                   out_valid_ff, skid_valid_ff;
   logic [RspDataBits-1:0] out_data_ff, skid_data_ff;

   assign fire       = req_tvalid && req_tready;
   assign restart    = req_tdata[0];
   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
         exec_times_ff <= '0;
         periods_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TASK_COUNT: task_count_ff <= csr_data[TaskBits-1:0];
            CSR_EXEC_TIMES: exec_times_ff <= csr_data;
            CSR_PERIODS:    periods_ff    <= csr_data;
            default:        ;
         endcase
      end
   end

   // Chain of task cells, slot 0 has the highest priority
   assign taken[0] = 1'b0;
   for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
      logic slot_active;
      assign slot_active = (TaskBits'(i) < task_count_ff);

      rmts_cell #(
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (fire),
         .restart   (restart),
         .active    (slot_active),
         .exec_time (exec_times_ff[PackBits*i +: TIME_BITS]),
         .period    (periods_ff[PackBits*i +: TIME_BITS]),
         .taken_in  (taken[i]),
         .taken_out (taken[i+1]),
         .stat      (stat[i])
      );

      assign run_vec[i]  = stat[i].runs;
      assign rel_vec[i]  = stat[i].released;
      assign miss_vec[i] = stat[i].missed;
   end

   // Encode the runner and widen the masks
   always_comb begin
      run_task = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         if (run_vec[i]) begin
            run_task = TaskBits'(i + 1);
         end
      end
   end

   assign rel_mask  = MaxSlots'(rel_vec);
   assign miss_mask = MaxSlots'(miss_vec);
   assign tick_cur  = restart ? '0 : tick_ff;
   assign rsp_new   = {4'b0, tick_cur, miss_mask, rel_mask, run_task};

   // Advance the tick counter
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (fire) begin
         tick_ff <= tick_cur + TickBits'(1);
      end
   end

   // Output register with a skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff  <= skid_valid_ff || fire;
         skid_valid_ff <= 1'b0;
      end else if (fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : rsp_new;
      end else if (fire) begin
         skid_data_ff <= rsp_new;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // At most one cell runs in a tick
   a_one_runner: assert property (@(posedge clock) disable iff (reset)
      $onehot0(run_vec))
      else $error("more than one task cell granted the run");

   // The grant leaving the chain marks that some cell ran
   a_grant_chain: assert property (@(posedge clock) disable iff (reset)
      taken[TASK_SLOTS] == (|run_vec))
      else $error("run grant at chain end disagrees with runner");

   // A miss only comes with a release
   a_miss_on_release: assert property (@(posedge clock) disable iff (reset)
      (miss_mask & ~rel_mask) == '0)
      else $error("miss flagged without release");

   // The skid entry fills only behind a held output
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // An accepted tick counts up unless restarted
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      fire && !restart |=> tick_ff == $past(tick_ff) + TickBits'(1))
      else $error("tick counter did not advance");

endmodule

// ===== rtl/rmts_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_cell: one task slot of the scheduler chain
// Holds the slot's remaining work and release countdown, releases the job
// when the countdown expires and runs it when no higher-priority cell ran.
// ----------------------------------------------------------------------------
module rmts_cell
   import rmts_pkg::*;
#(
   parameter int TIME_BITS = TimeBitsDef
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,        // one tick is taken this cycle
   input  logic                 restart,     // clear job state before the tick
   input  logic                 active,      // slot below the task count
   input  logic [TIME_BITS-1:0] exec_time,
   input  logic [TIME_BITS-1:0] period,
   input  logic                 taken_in,    // a higher-priority cell runs
   output logic                 taken_out,   // this cell or one above runs
   output cell_stat_type        stat
);

   logic [TIME_BITS-1:0] work_ff, work_in;
   logic [TIME_BITS-1:0] cnt_ff, cnt_in;
   logic [TIME_BITS-1:0] work_cur, cnt_cur, work_rel, reload;
   logic                 rel, runs;

   // Apply restart, then release when the countdown has expired
   always_comb begin
      work_cur = restart ? '0 : work_ff;
      cnt_cur  = restart ? '0 : cnt_ff;
      rel      = active && (cnt_cur == '0);
      reload   = (period == '0) ? '0 : period - TIME_BITS'(1);
      work_rel = rel ? exec_time : work_cur;
      runs     = active && !taken_in && (work_rel != '0);

      if (!active) begin
         cnt_in = cnt_cur;
      end else if (rel) begin
         cnt_in = reload;
      end else begin
         cnt_in = cnt_cur - TIME_BITS'(1);
      end
      work_in = runs ? work_rel - TIME_BITS'(1) : work_rel;

      taken_out     = taken_in || runs;
      stat.released = rel;
      stat.missed   = rel && (work_cur != '0);
      stat.runs     = runs;
   end

   // Advance the slot state once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= '0;
         cnt_ff  <= '0;
      end else if (step) begin
         work_ff <= work_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the rate-monotonic tick scheduler
// Drives scheduler ticks through the req stream and writes the task table
// over csr. A tick scoreboard tracks job state and predicts each result,
// which is compared field by field as it leaves the rsp stream. The sender
// works in bursts and the receiver stalls, with one long receiver hold-off
// so that the output buffer fills and the input stalls.
// ----------------------------------------------------------------------------
module testbench;
   import rmts_pkg::*;

   localparam int Slots       = TaskSlotsDef;
   localparam int TimeBits    = TimeBitsDef;
   localparam int PhaseCount  = 10;
   localparam int PhaseTicks  = 75;
   localparam int HoldOffLen  = 60;
   localparam int LimitCycles = 200000;
   localparam logic [CsrIdxBits-1:0] CsrUnusedIdx = 2'd3;

   // One expected scheduler result
   typedef struct packed {
      logic [TickBits-1:0] tick_index;
      logic [MaxSlots-1:0] miss_mask;
      logic [MaxSlots-1:0] released_mask;
      logic [TaskBits-1:0] running_task;
   } tick_result_type;

   // Tracks task state, predicts each tick and checks the results
   class tick_scoreboard;
      logic [3:0]          task_count;
      logic [63:0]         exec_times;
      logic [63:0]         periods;
      logic [TimeBits-1:0] work_left [Slots];
      logic [TimeBits-1:0] countdown [Slots];
      logic [TickBits-1:0] tick_count;
      tick_result_type     expected_q [$];
      int                  errors;

      function new();
         task_count = '0;
         exec_times = '0;
         periods    = '0;
         errors     = 0;
         clear_jobs();
      endfunction

      function void clear_jobs();
         for (int i = 0; i < Slots; i++) begin
            work_left[i] = '0;
            countdown[i] = '0;
         end
         tick_count = '0;
      endfunction

      function logic [TimeBits-1:0] slot_time(logic [63:0] word, int slot);
         return word[PackBits*slot +: TimeBits];
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Apply a register write; unknown indexes are dropped
      function void write_reg(logic [CsrIdxBits-1:0] idx, logic [63:0] value);
         if (idx == CSR_TASK_COUNT) begin
            task_count = value[3:0];
         end else if (idx == CSR_EXEC_TIMES) begin
            exec_times = value;
         end else if (idx == CSR_PERIODS) begin
            periods = value;
         end
      endfunction

      // Advance one tick and queue its expected result
      function void note_tick(logic restart);
         int unsigned         active;
         logic [TimeBits-1:0] per;
         tick_result_type     res;
         active = (task_count > Slots) ? Slots : task_count;
         res = '0;
         if (restart) clear_jobs();
         // release due tasks, count down the rest
         for (int i = 0; i < active; i++) begin
            if (countdown[i] == 0) begin
               per = slot_time(periods, i);
               if (per == 0) per = 1;
               if (work_left[i] != 0) res.miss_mask[i] = 1'b1;
               res.released_mask[i] = 1'b1;
               work_left[i] = slot_time(exec_times, i);
               countdown[i] = per - 1'b1;
            end else begin
               countdown[i] = countdown[i] - 1'b1;
            end
         end
         // highest priority task with work runs
         for (int i = 0; i < active; i++) begin
            if (res.running_task == 0 && work_left[i] != 0) begin
               work_left[i] = work_left[i] - 1'b1;
               res.running_task = TaskBits'(i + 1);
            end
         end
         res.tick_index = tick_count;
         tick_count = tick_count + 1'b1;
         expected_q.push_back(res);
      endfunction

      // Compare an accepted result with the oldest expectation
      function void check_result(logic [RspDataBits-1:0] data);
         tick_result_type exp_res;
         tick_result_type got;
         got = data[$bits(tick_result_type)-1:0];
         if (expected_q.size() == 0) begin
            $error("result with no tick pending: %h", data);
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (got.running_task !== exp_res.running_task) begin
            $error("running_task: expected %0d, got %0d",
                   exp_res.running_task, got.running_task);
            errors++;
         end
         if (got.released_mask !== exp_res.released_mask) begin
            $error("released_mask: expected %b, got %b",
                   exp_res.released_mask, got.released_mask);
            errors++;
         end
         if (got.miss_mask !== exp_res.miss_mask) begin
            $error("miss_mask: expected %b, got %b", exp_res.miss_mask, got.miss_mask);
            errors++;
         end
         if (got.tick_index !== exp_res.tick_index) begin
            $error("tick_index: expected %0d, got %0d",
                   exp_res.tick_index, got.tick_index);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata = '0;     // [0] restart
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;          // [3:0] running_task,
                                               // [11:4] released_mask,
                                               // [19:12] miss_mask,
                                               // [35:20] tick_index
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxBits-1:0]  csr_index = '0;
   logic [CsrDataBits-1:0] csr_data = '0;

   tick_scoreboard ticks;
   bit             sender_gaps = 1'b1;
   bit             rsp_stalls  = 1'b1;
   bit             hold_off_req = 1'b0;
   int unsigned    burst_left = 0;

   rate_monotonic_tick_scheduler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Check every result taken from the block
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ticks.check_result(rsp_tdata);
   end

   // Receiver: random stall pattern, plus one long hold-off on request
   initial begin : rsp_side
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldOffLen) @(posedge clock);
         end else if (rsp_stalls && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // Offer one tick, hold it until taken, then maybe leave a gap
   task automatic send_tick(input logic restart);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataBits-1){1'b0}}, restart};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks.note_tick(restart);
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if (sender_gaps) begin
            gap = $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Send a run of ticks; restart comes once in restart_odds (0: never)
   task automatic run_ticks(input int count, input int unsigned restart_odds);
      for (int k = 0; k < count; k++) begin
         send_tick(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
      end
   endtask

   // Drop the offer, wait until every pending result is out and the block is quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (ticks.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the task table while the block is idle
   task automatic load_config(input logic [3:0] tc, input logic [63:0] ex,
                              input logic [63:0] pe, input bit poke_unused);
      logic [CsrIdxBits-1:0] idx [4];
      logic [63:0]           val [4];
      logic [63:0]           tc_word;
      int                    n;
      settle();
      tc_word = {$urandom, $urandom};
      tc_word[3:0] = tc;
      idx = '{CSR_PERIODS, CSR_EXEC_TIMES, CsrUnusedIdx, CSR_TASK_COUNT};
      val = '{pe, ex, {$urandom, $urandom}, tc_word};
      for (int k = 0; k < 4; k++) begin
         if (idx[k] != CsrUnusedIdx || poke_unused) begin
            csr_valid <= 1'b1;
            csr_index <= idx[k];
            csr_data  <= val[k];
            @(posedge clock);
            while (!csr_ready) @(posedge clock);
            ticks.write_reg(idx[k], val[k]);
         end
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [3:0]  tc;
      logic [63:0] ex;
      logic [63:0] pe;
      int unsigned per;
      int unsigned prev;
      int unsigned odds;
      ticks = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // No active tasks: idle ticks, restart resets the tick number
      send_tick(1'b0);
      send_tick(1'b1);
      run_ticks(1, 0);

      // Three tasks: zero period, zero exec time, misses; upper slots inactive
      load_config(4'd3, 64'hFFFF_FFFF_FF03_0200, 64'h0909_0909_0905_0300, 1'b1);
      run_ticks(5, 0);
      send_tick(1'b1);
      run_ticks(5, 0);

      // Count beyond the slots saturates; all fields at their maximum
      load_config(4'hF, '1, '1, 1'b0);
      run_ticks(4, 0);

      // All slots due every tick with two ticks of work: constant misses
      load_config(4'd8, 64'h0202_0202_0202_0202, 64'h0101_0101_0101_0101, 1'b1);
      run_ticks(3, 0);
      send_tick(1'b1);
      run_ticks(2, 0);

      // Random task tables, idling and restarts
      for (int ph = 0; ph < PhaseCount; ph++) begin
         tc = (ph < 2) ? 4'd8 : 4'($urandom_range(0, 15));
         ex = '0;
         pe = '0;
         if (ph == 3) begin
            ex = {$urandom, $urandom};
            pe = {$urandom, $urandom};
         end else if (ph == 4) begin
            ex = '1;
            pe = {$urandom, $urandom} & 64'h0303_0303_0303_0303;
         end else begin
            // ascending periods with mostly feasible work
            prev = $urandom_range(0, 3);
            for (int s = 0; s < Slots; s++) begin
               per = prev + $urandom_range(0, 6);
               if ($urandom_range(0, 15) == 0) per = 0;
               if (per > 255) per = 255;
               pe[s*PackBits +: PackBits] = 8'(per);
               ex[s*PackBits +: PackBits] = 8'($urandom_range(0, (per < 2) ? 2 : per / 2));
               prev = per;
            end
         end
         load_config(tc, ex, pe, ph % 3 == 0);
         sender_gaps = (ph != 1 && ph != 5) && $urandom_range(0, 3) != 0;
         rsp_stalls  = (ph != 5) && $urandom_range(0, 3) != 0;
         // long receiver hold-off while the sender keeps pushing
         if (ph == 1) hold_off_req = 1'b1;
         odds = (ph == 6) ? 5 : 60;
         run_ticks(PhaseTicks, odds);
      end

      settle();
      repeat (5) @(posedge clock);
      if (ticks.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #(LimitCycles * 20);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
